@@ rtl/core/cvn_pkg.sv @@
package cvn_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam logic [31:0] HASH_GOLDEN = 32'h9e37_79b9;
  localparam int          HASH_OUT_W  = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int STR_W      = 24;
  localparam int GRAD_W     = 25;
  localparam int MAG_W      = 32;
  localparam int RAD_W      = 64;
  localparam int FORCE_W    = 32;

  localparam logic [16:0] LEVEL_ONE  = 17'd65536;
  localparam logic [16:0] LEVEL_BASE = 17'd19661;
  localparam logic [15:0] LEVEL_GAIN = 16'd45875;
  localparam logic [32:0] LEVEL_RND  = 33'd32768;

  localparam logic [CFG_DATA_W-1:0] STRENGTH_RST = 24'd65536;
  localparam logic [CFG_DATA_W-1:0] SCALE_RST    = 24'd65536;
  localparam logic [CFG_DATA_W-1:0] RATE_RST     = 24'd65536;

  // square root: two result bits per stage
  localparam int SQ_STEPS_PER_STAGE = 2;
  localparam int SQ_STAGES          = MAG_W / SQ_STEPS_PER_STAGE;

  // divider: 55-bit numerator padded to 56, two quotient bits per stage
  localparam int DIV_W               = 56;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = DIV_W / DIV_STEPS_PER_STAGE;

  localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7fff_ffff;
  localparam logic [FORCE_W-1:0] FORCE_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_STRENGTH = 4'd0,
    REG_SPACE_SCALE    = 4'd1,
    REG_TIME_RATE      = 4'd2,
    REG_AUDIO_MODE     = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [STR_W-1:0]         str;
  } grad_side_t;

  typedef struct packed {
    logic [MAG_W+1:0] rem;
    logic [MAG_W-1:0] root;
    logic [RAD_W-1:0] rad;
  } sq_state_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] quo;
    logic             neg;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t         lx;
    dv_lane_t         ly;
    logic [MAG_W-1:0] mag;
  } dv_stage_t;

  function automatic logic [31:0] hash_mix(logic [31:0] h, logic [31:0] c);
    logic [31:0] sum;
    sum = c + HASH_GOLDEN + {h[25:0], 6'b0} + {2'b0, h[31:2]};
    return h ^ sum;
  endfunction

  function automatic logic [HASH_OUT_W-1:0] hash_fin(logic [31:0] h);
    logic [31:0] a;
    a = h ^ {h[18:0], 13'b0};
    a = a ^ {17'b0, a[31:17]};
    a = a ^ {a[26:0], 5'b0};
    return a[HASH_OUT_W-1:0];
  endfunction

  function automatic sq_state_t sq_step(sq_state_t s);
    logic [MAG_W+3:0] rem2;
    logic [MAG_W+3:0] trial;
    sq_state_t        r;
    rem2  = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r     = s;
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = (MAG_W+2)'(rem2 - trial);
      r.root = {s.root[MAG_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2[MAG_W+1:0];
      r.root = {s.root[MAG_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_lane_t dv_step(dv_lane_t l, logic [MAG_W-1:0] mag);
    logic [MAG_W:0] rem2;
    dv_lane_t       r;
    rem2  = {l.rem, l.num[DIV_W-1]};
    r     = l;
    r.num = {l.num[DIV_W-2:0], 1'b0};
    if (rem2 >= {1'b0, mag}) begin
      r.rem = MAG_W'(rem2 - {1'b0, mag});
      r.quo = {l.quo[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = rem2[MAG_W-1:0];
      r.quo = {l.quo[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [FORCE_W-1:0] dv_sat(dv_lane_t l, logic zero);
    logic [FORCE_W-1:0] res;
    if (zero) begin
      res = '0;
    end else if (l.neg) begin
      if ((|l.quo[DIV_W-1:32]) || (l.quo[31] && (|l.quo[30:0])))
        res = FORCE_MIN;
      else
        res = FORCE_W'(-l.quo[31:0]);
    end else begin
      if (|l.quo[DIV_W-1:31])
        res = FORCE_MAX;
      else
        res = l.quo[31:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/cvn_sqrt.sv @@
module cvn_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [63:0]              in_rad,
  input  cvn_pkg::grad_side_t      in_side,
  output logic                     out_vld,
  output logic [31:0]              out_root,
  output cvn_pkg::grad_side_t      out_side
);
  import cvn_pkg::*;

  logic [SQ_STAGES-1:0] vld_r;
  sq_state_t            st_r   [SQ_STAGES];
  sq_state_t            st_nxt [SQ_STAGES];
  sq_state_t            src    [SQ_STAGES];
  grad_side_t           side_r [SQ_STAGES];

  always_comb begin
    src[0] = '{rem: '0, root: '0, rad: in_rad};
    for (int i = 1; i < SQ_STAGES; i++) src[i] = st_r[i-1];
  end

  // two digit steps per stage
  always_comb begin
    for (int i = 0; i < SQ_STAGES; i++) begin
      st_nxt[i] = src[i];
      for (int j = 0; j < SQ_STEPS_PER_STAGE; j++) st_nxt[i] = sq_step(st_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 0; i < SQ_STAGES; i++) st_r[i] <= st_nxt[i];
      for (int i = 1; i < SQ_STAGES; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = st_r[SQ_STAGES-1].root;
  assign out_side = side_r[SQ_STAGES-1];

endmodule

@@ rtl/core/cvn_div.sv @@
module cvn_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [31:0]             in_mag,
  input  logic signed [24:0]      in_cx,
  input  logic signed [24:0]      in_cy,
  input  logic [23:0]             in_str,
  output logic                    out_vld,
  output logic [31:0]             out_fx,
  output logic [31:0]             out_fy
);
  import cvn_pkg::*;

  localparam int N = DIV_STAGES + 1;

  logic [N-1:0]         vld_r;
  dv_stage_t            st_r   [N];
  dv_stage_t            st_nxt [N];
  logic [GRAD_W-1:0]    ax_c;
  logic [GRAD_W-1:0]    ay_c;
  logic [2*STR_W-1:0]   px_c;
  logic [2*STR_W-1:0]   py_c;
  logic                 zero_c;

  // front stage: magnitudes times strength, q7 scale
  always_comb begin
    ax_c = in_cx[GRAD_W-1] ? GRAD_W'(-in_cx) : GRAD_W'(in_cx);
    ay_c = in_cy[GRAD_W-1] ? GRAD_W'(-in_cy) : GRAD_W'(in_cy);
    px_c = (2*STR_W)'(ax_c[STR_W-1:0]) * (2*STR_W)'(in_str);
    py_c = (2*STR_W)'(ay_c[STR_W-1:0]) * (2*STR_W)'(in_str);
    st_nxt[0].mag    = in_mag;
    st_nxt[0].lx.rem = '0;
    st_nxt[0].lx.quo = '0;
    st_nxt[0].lx.neg = in_cx[GRAD_W-1];
    st_nxt[0].lx.num = {1'b0, px_c, 7'b0};
    st_nxt[0].ly.rem = '0;
    st_nxt[0].ly.quo = '0;
    st_nxt[0].ly.neg = in_cy[GRAD_W-1];
    st_nxt[0].ly.num = {1'b0, py_c, 7'b0};
    for (int i = 1; i < N; i++) begin
      st_nxt[i] = st_r[i-1];
      for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
        st_nxt[i].lx = dv_step(st_nxt[i].lx, st_r[i-1].mag);
        st_nxt[i].ly = dv_step(st_nxt[i].ly, st_r[i-1].mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign zero_c  = (st_r[N-1].mag == '0);
  assign out_vld = vld_r[N-1];
  assign out_fx  = dv_sat(st_r[N-1].lx, zero_c);
  assign out_fy  = dv_sat(st_r[N-1].ly, zero_c);

endmodule

@@ rtl/core/curl_value_noise_force.sv @@
// channel | dir | beat contents                                   | handshake
// --------+-----+-------------------------------------------------+----------------------
// in_     | in  | pos_x, pos_y, particle_seed, time_now, level    | in_valid / in_ready
// out_    | out | force_x, force_y                                | out_valid / out_ready
// cfg_    | in  | cfg_index, cfg_wdata                            | cfg_valid / cfg_ready
//
// one beat per cycle sustained while the output is not stalled; from in beat to out beat:
// 10 front stages, 16 square root stages, 29 divider stages, 1 output register
// reset is synchronous and clears valids, skid and config registers
// one global advance moves the whole pipeline; it drops only while the
// skid register behind a stalled output holds a beat, and returns the cycle
// after that output beat is taken
module curl_value_noise_force #(
  parameter int COORD_FRAC_BITS = cvn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_y,
  input  logic [31:0]                     in_particle_seed,
  input  logic [31:0]                     in_time_now,
  input  logic [16:0]                     in_audio_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_force_x,
  output logic signed [31:0]              out_force_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cvn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cvn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cvn_pkg::*;

  localparam int          F     = COORD_FRAC_BITS;
  localparam int          SH    = 32 - F;
  localparam logic [31:0] EPS   = 32'(((64'd1 << F) + 64'd50) / 64'd100);
  localparam logic [F:0]  ONE   = (F+1)'(1) << F;
  localparam logic [F+1:0] THREE = (F+2)'(3) << F;
  localparam int          FRONT = 10;
  // coordinate slot of each sample: x+eps, x-eps, then y+eps, y-eps
  localparam int          XK [4] = '{1, 2, 0, 0};
  localparam int          YK [4] = '{3, 3, 4, 5};

  // ---------------- configuration ----------------
  logic [STR_W-1:0] field_strength_r;
  logic [STR_W-1:0] space_scale_r;
  logic [STR_W-1:0] time_rate_r;
  logic             audio_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_strength_r <= STRENGTH_RST;
      space_scale_r    <= SCALE_RST;
      time_rate_r      <= RATE_RST;
      audio_mode_r     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIELD_STRENGTH: field_strength_r <= cfg_wdata;
        REG_SPACE_SCALE:    space_scale_r    <= cfg_wdata;
        REG_TIME_RATE:      time_rate_r      <= cfg_wdata;
        REG_AUDIO_MODE:     audio_mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic              adv;
  logic [FRONT-1:0]  fv_r;
  logic              out_vld_r;
  logic [31:0]       out_fx_r;
  logic [31:0]       out_fy_r;
  logic              skid_vld_r;
  logic [31:0]       skid_fx_r;
  logic [31:0]       skid_fy_r;

  assign adv      = !skid_vld_r;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (adv) begin
      fv_r <= {fv_r[FRONT-2:0], in_valid};
    end
  end

  // ---------------- stage 1: scale products, level factor ----------------
  logic signed [56:0] pxp_c;
  logic signed [56:0] pyp_c;
  logic [55:0]        tp_c;
  logic [16:0]        lvl_c;
  logic [32:0]        lvl_prod_c;
  logic [16:0]        factor_c;

  logic signed [56:0] pxp1_r;
  logic signed [56:0] pyp1_r;
  logic [55:0]        tp1_r;
  logic [16:0]        factor1_r;
  logic [31:0]        seed1_r;

  assign pxp_c = $signed(in_pos_x) * $signed({1'b0, space_scale_r});
  assign pyp_c = $signed(in_pos_y) * $signed({1'b0, space_scale_r});
  assign tp_c  = 56'(in_time_now) * 56'(time_rate_r);

  always_comb begin
    // level saturates at one; audio off means level one
    if (!audio_mode_r)                    lvl_c = LEVEL_ONE;
    else if (in_audio_level > LEVEL_ONE)  lvl_c = LEVEL_ONE;
    else                                  lvl_c = in_audio_level;
    lvl_prod_c = 33'(LEVEL_GAIN) * 33'(lvl_c) + LEVEL_RND;
    factor_c   = LEVEL_BASE + 17'(lvl_prod_c[31:16]);
  end

  // ---------------- stage 2: sample point, effective strength ----------------
  logic [31:0]        x2_r;
  logic [31:0]        y2_r;
  logic [31:0]        seed2_r;
  logic [40:0]        sprod_c;
  // strength rides along from stage 2 to stage 9
  logic [STR_W-1:0]   str_r [FRONT-2];

  assign sprod_c = 41'(field_strength_r) * 41'(factor1_r);

  // ---------------- stage 3: the six coordinates ----------------
  logic [31:0] c3_r [6];
  logic [31:0] seed3_r;

  // ---------------- stage 4: lattice index, t*t, first hash round ----------------
  logic [31:0]    idx_c   [6];
  logic [2*F-1:0] tt_c    [6];
  logic [31:0]    h1_c    [3][2];
  logic [31:0]    idx4_r  [6];
  logic [F-1:0]   t4_r    [6];
  logic [2*F-1:0] tt4_r   [6];
  logic [31:0]    h1_4_r  [3][2];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      idx_c[k] = 32'($signed(c3_r[k]) >>> F);
      tt_c[k]  = (2*F)'(c3_r[k][F-1:0]) * (2*F)'(c3_r[k][F-1:0]);
    end
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < 2; d++) h1_c[k][d] = hash_mix(seed3_r, idx_c[k] + 32'(d));
    end
  end

  // ---------------- stage 5: smoothstep weight, second hash round ----------------
  logic [F+1:0]   wgt_c   [6];
  logic [2*F+1:0] ep_c    [6];
  logic [31:0]    h2_c    [4][4];
  logic [F:0]     s5_r    [6];
  logic [31:0]    h2_5_r  [4][4];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      wgt_c[k] = THREE - (F+2)'({t4_r[k], 1'b0});
      ep_c[k]  = (2*F+2)'(tt4_r[k][2*F-1:F]) * (2*F+2)'(wgt_c[k]);
    end
    for (int j = 0; j < 4; j++) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          h2_c[j][dy*2+dx] = hash_mix(h1_4_r[XK[j]][dx], idx4_r[YK[j]] + 32'(dy));
        end
      end
    end
  end

  // ---------------- stage 6: corner values, blend along x ----------------
  logic [HASH_OUT_W-1:0] v_c   [4][4];
  logic [F+25:0]         acc6_c [4][2];
  logic [HASH_OUT_W-1:0] b6_r  [4][2];
  logic [F:0]            sy6_r [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int c = 0; c < 4; c++) v_c[j][c] = hash_fin(h2_5_r[j][c]);
      for (int dy = 0; dy < 2; dy++) begin
        acc6_c[j][dy] = (F+26)'(v_c[j][dy*2])   * (F+26)'(ONE - s5_r[XK[j]])
                      + (F+26)'(v_c[j][dy*2+1]) * (F+26)'(s5_r[XK[j]]);
      end
    end
  end

  // ---------------- stage 7: blend along y ----------------
  logic [F+25:0]         acc7_c [4];
  logic [HASH_OUT_W-1:0] n7_r   [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc7_c[j] = (F+26)'(b6_r[j][0]) * (F+26)'(ONE - sy6_r[j])
                + (F+26)'(b6_r[j][1]) * (F+26)'(sy6_r[j]);
    end
  end

  // ---------------- stages 8..10: gradient, squares, radicand ----------------
  logic signed [GRAD_W-1:0]   gx8_r;
  logic signed [GRAD_W-1:0]   gy8_r;
  logic signed [2*GRAD_W-1:0] sqx_c;
  logic signed [2*GRAD_W-1:0] sqy_c;
  logic [47:0]                sqx9_r;
  logic [47:0]                sqy9_r;
  logic signed [GRAD_W-1:0]   gx9_r;
  logic signed [GRAD_W-1:0]   gy9_r;
  logic [48:0]                ssum_c;
  logic [RAD_W-1:0]           rad10_r;
  grad_side_t                 side10_r;

  assign sqx_c  = gx8_r * gx8_r;
  assign sqy_c  = gy8_r * gy8_r;
  assign ssum_c = 49'(sqx9_r) + 49'(sqy9_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      pxp1_r    <= pxp_c;
      pyp1_r    <= pyp_c;
      tp1_r     <= tp_c;
      factor1_r <= factor_c;
      seed1_r   <= in_particle_seed;
      // stage 2: coordinates wrap to 32 bits
      x2_r      <= pxp1_r[SH +: 32] + tp1_r[SH +: 32];
      y2_r      <= pyp1_r[SH +: 32] - tp1_r[SH +: 32];
      seed2_r   <= seed1_r;
      str_r[0]  <= sprod_c[39:16];
      for (int i = 1; i < FRONT - 2; i++) str_r[i] <= str_r[i-1];
      // stage 3
      c3_r[0]   <= x2_r;
      c3_r[1]   <= x2_r + EPS;
      c3_r[2]   <= x2_r - EPS;
      c3_r[3]   <= y2_r;
      c3_r[4]   <= y2_r + EPS;
      c3_r[5]   <= y2_r - EPS;
      seed3_r   <= seed2_r;
      // stage 4
      for (int k = 0; k < 6; k++) begin
        idx4_r[k] <= idx_c[k];
        t4_r[k]   <= c3_r[k][F-1:0];
        tt4_r[k]  <= tt_c[k];
      end
      h1_4_r    <= h1_c;
      // stage 5
      for (int k = 0; k < 6; k++) s5_r[k] <= ep_c[k][2*F:F];
      h2_5_r    <= h2_c;
      // stage 6
      for (int j = 0; j < 4; j++) begin
        for (int dy = 0; dy < 2; dy++) b6_r[j][dy] <= acc6_c[j][dy][F +: HASH_OUT_W];
        sy6_r[j] <= s5_r[YK[j]];
      end
      // stage 7
      for (int j = 0; j < 4; j++) n7_r[j] <= acc7_c[j][F +: HASH_OUT_W];
      // stage 8: plain differences, no 2*eps divide
      gx8_r     <= $signed({1'b0, n7_r[0]}) - $signed({1'b0, n7_r[1]});
      gy8_r     <= $signed({1'b0, n7_r[2]}) - $signed({1'b0, n7_r[3]});
      // stage 9
      sqx9_r    <= sqx_c[47:0];
      sqy9_r    <= sqy_c[47:0];
      gx9_r     <= gx8_r;
      gy9_r     <= gy8_r;
      // stage 10: (gx^2 + gy^2) * 2^14
      rad10_r   <= RAD_W'({ssum_c, 14'b0});
      side10_r  <= '{gx: gx9_r, gy: gy9_r, str: str_r[FRONT-3]};
    end
  end

  // ---------------- length ----------------
  logic        sq_vld;
  logic [31:0] sq_root;
  grad_side_t  sq_side;

  cvn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (fv_r[FRONT-1]),
    .in_rad   (rad10_r),
    .in_side  (side10_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------- normalize and scale: rotated gradient (-gy, gx) ----------------
  logic                     dv_vld;
  logic [31:0]              dv_fx;
  logic [31:0]              dv_fy;
  logic signed [GRAD_W-1:0] cx_c;

  assign cx_c = GRAD_W'(-sq_side.gy);

  cvn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (sq_vld),
    .in_mag  (sq_root),
    .in_cx   (cx_c),
    .in_cy   (sq_side.gx),
    .in_str  (sq_side.str),
    .out_vld (dv_vld),
    .out_fx  (dv_fx),
    .out_fy  (dv_fy)
  );

  // ---------------- output register with skid ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_ready) begin
      // output held: a beat leaving the pipeline parks in the skid
      if (adv && dv_vld) skid_vld_r <= 1'b1;
    end else begin
      out_vld_r  <= skid_vld_r || (adv && dv_vld);
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_ready) begin
      if (adv && dv_vld) begin
        skid_fx_r <= dv_fx;
        skid_fy_r <= dv_fy;
      end
    end else if (skid_vld_r) begin
      out_fx_r <= skid_fx_r;
      out_fy_r <= skid_fy_r;
    end else begin
      out_fx_r <= dv_fx;
      out_fy_r <= dv_fy;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_force_x = $signed(out_fx_r);
  assign out_force_y = $signed(out_fy_r);

endmodule

@@ rtl/core/cvn_checker.sv @@
module cvn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_force_x,
  input logic [31:0] out_force_y
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_force_x) && $stable(out_force_y))
    else $error("out beat changed under stall");

  // reset empties the output and skid
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output or skid not cleared by reset");

  // input side only blocks while a result waits
  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with empty output");

  // a taken output drains the skid in the following cycle
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("skid did not drain");

endmodule

bind curl_value_noise_force cvn_checker u_cvn_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_force_x (out_force_x),
  .out_force_y (out_force_y)
);
